// ===== rtl/gregorian_date_add_days_macros.svh =====
// Assertion macros shared by the date adder RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef GREGORIAN_DATE_ADD_DAYS_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_MACROS_SVH

`ifndef ASSERT_OFF
// Check that cons holds in the same cycle as ante.
`define GDAD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that cons holds in the cycle after ante.
`define GDAD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GDAD_ASSERT_IMP(lbl, ante, cons, msg)
`define GDAD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/gdad_pkg.sv =====
// Shared types, constants and calendar helpers for the date adder.
// No dependencies; used by gdad_seq and gregorian_date_add_days.
package gdad_pkg;

	localparam logic [13:0] YEAR_MAX    = 14'd9999;
	localparam logic [13:0] YEAR_CYCLE  = 14'd400;
	localparam logic [8:0]  CYCLE_LAST  = 9'd399;
	localparam logic [8:0]  DAYS_LEAP   = 9'd366;
	localparam logic [8:0]  DAYS_COMMON = 9'd365;
	localparam logic [3:0]  MONTH_FIRST = 4'd1;
	localparam logic [3:0]  MONTH_FEB   = 4'd2;
	localparam logic [3:0]  MONTH_LAST  = 4'd12;
	localparam logic [4:0]  DAY_LAST    = 5'd31;

	localparam logic [4:0] MONTH_LEN [0:12] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_CLAMP,
		S_MSUM,
		S_ADDCNT,
		S_YEAR,
		S_MONTH,
		S_DONE
	} state_t;

	// Finished result handed from the sequencer to the output register
	typedef struct packed {
		logic        valid;
		logic        over;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} done_t;

	// Leap status from the year's position in the 400-year cycle
	function automatic logic leap_of(input logic [8:0] r);
		logic century;
		century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
		return (r == 9'd0) || ((r[1:0] == 2'd0) && !century);
	endfunction

	// Length of a month, February stretched in leap years
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [3:0] idx;
		logic [4:0] len;
		idx = (m == 4'd0) ? MONTH_FIRST : ((m > MONTH_LAST) ? MONTH_LAST : m);
		len = MONTH_LEN[idx];
		if ((idx == MONTH_FEB) && leap) begin
			len = 5'd29;
		end
		return len;
	endfunction

endpackage

// ===== rtl/gdad_alu.sv =====
// Shared add/subtract unit with sign and zero flags.
// No dependencies; driven by gdad_seq through the top level.
module gdad_alu #(
	parameter int W = 22
) (
	input  logic [W-1:0] op_a,
	input  logic [W-1:0] op_b,
	input  logic         sub,
	output logic [W-1:0] value,
	output logic         neg,
	output logic         zero
);

	logic [W:0] full;

	// Add or subtract at one extra bit to catch the borrow
	always_comb begin
		if (sub) begin
			full = {1'b0, op_a} - {1'b0, op_b};
		end else begin
			full = {1'b0, op_a} + {1'b0, op_b};
		end
	end

	assign value = full[W-1:0];
	assign neg   = sub & full[W];
	assign zero  = (full[W-1:0] == '0);

endmodule

// ===== rtl/gdad_seq.sv =====
// Sequencer and working registers of the date adder.
// Uses gdad_pkg and the assertion macros; drives the shared gdad_alu.
`include "gregorian_date_add_days_macros.svh"

module gdad_seq
	import gdad_pkg::*;
#(
	parameter int COUNT_WIDTH = 20,
	parameter int UNIT_W      = 22
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [13:0]            start_year,
	input  logic [3:0]             start_month,
	input  logic [4:0]             start_day,
	input  logic [COUNT_WIDTH-1:0] count,
	output logic                   busy,
	output logic [UNIT_W-1:0]      alu_a,
	output logic [UNIT_W-1:0]      alu_b,
	output logic                   alu_sub,
	input  logic [UNIT_W-1:0]      alu_value,
	input  logic                   alu_neg,
	input  logic                   alu_zero,
	output done_t                  done,
	input  logic                   take
);

	state_t                 state_q, state_d;
	logic [UNIT_W-1:0]      acc_q;
	logic [13:0]            year_q;
	logic [8:0]             r400_q;
	logic [3:0]             month_q;
	logic [4:0]             day_q;
	logic [3:0]             mcnt_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   over_q;

	logic       leap;
	logic       alu_gt;
	logic [4:0] mlen;
	logic [4:0] dmax;
	logic [4:0] day_c;
	logic [13:0] year_c;
	logic [3:0]  month_c;

	assign leap   = leap_of(r400_q);
	assign alu_gt = !alu_neg && !alu_zero;
	assign mlen   = month_days(mcnt_q, leap);
	assign dmax   = month_days(month_q, leap);

	// Clean up the incoming date fields
	assign year_c  = (start_year == 14'd0) ? 14'd1 : start_year;
	assign month_c = (start_month == 4'd0) ? MONTH_FIRST :
		((start_month > MONTH_LAST) ? MONTH_LAST : start_month);
	assign day_c   = (day_q == 5'd0) ? 5'd1 : ((day_q > dmax) ? dmax : day_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (year_c > YEAR_MAX) ? S_DONE : S_MOD;
				end
			end
			S_MOD: begin
				if (alu_neg) begin
					state_d = S_CLAMP;
				end
			end
			S_CLAMP: state_d = S_MSUM;
			S_MSUM: begin
				if (mcnt_q >= month_q) begin
					state_d = S_ADDCNT;
				end
			end
			S_ADDCNT: state_d = S_YEAR;
			S_YEAR: begin
				if (!alu_gt) begin
					state_d = S_MONTH;
				end else if (year_q >= YEAR_MAX) begin
					state_d = S_DONE;
				end
			end
			S_MONTH: begin
				if (!((mcnt_q < MONTH_LAST) && alu_gt)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Operand selection for the shared unit
	always_comb begin
		alu_a   = acc_q;
		alu_b   = '0;
		alu_sub = 1'b1;
		unique case (state_q)
			S_MOD:    alu_b = UNIT_W'(YEAR_CYCLE);
			S_MSUM: begin
				alu_b   = UNIT_W'(mlen);
				alu_sub = 1'b0;
			end
			S_ADDCNT: begin
				alu_b   = UNIT_W'(count_q);
				alu_sub = 1'b0;
			end
			S_YEAR:   alu_b = UNIT_W'(leap ? DAYS_LEAP : DAYS_COMMON);
			S_MONTH:  alu_b = UNIT_W'(mlen);
			default:  alu_b = '0;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// Present the finished date, saturated on overflow
	always_comb begin
		done.valid = (state_q == S_DONE);
		done.over  = over_q;
		done.year  = over_q ? YEAR_MAX : year_q;
		done.month = over_q ? MONTH_LAST : mcnt_q;
		done.day   = over_q ? DAY_LAST : acc_q[4:0];
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers: advance the accumulator and counters per step
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					year_q  <= year_c;
					month_q <= month_c;
					day_q   <= start_day;
					count_q <= count;
					acc_q   <= UNIT_W'(year_c);
					over_q  <= (year_c > YEAR_MAX);
				end
			end
			S_MOD: begin
				if (alu_neg) begin
					r400_q <= acc_q[8:0];
				end else begin
					acc_q <= alu_value;
				end
			end
			S_CLAMP: begin
				acc_q  <= UNIT_W'(day_c);
				mcnt_q <= MONTH_FIRST;
			end
			S_MSUM: begin
				if (mcnt_q < month_q) begin
					acc_q  <= alu_value;
					mcnt_q <= mcnt_q + 4'd1;
				end
			end
			S_ADDCNT: acc_q <= alu_value;
			S_YEAR: begin
				if (!alu_gt) begin
					mcnt_q <= MONTH_FIRST;
				end else if (year_q >= YEAR_MAX) begin
					over_q <= 1'b1;
				end else begin
					acc_q  <= alu_value;
					year_q <= year_q + 14'd1;
					r400_q <= (r400_q == CYCLE_LAST) ? 9'd0 : r400_q + 9'd1;
				end
			end
			S_MONTH: begin
				if ((mcnt_q < MONTH_LAST) && alu_gt) begin
					acc_q  <= alu_value;
					mcnt_q <= mcnt_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

	`GDAD_ASSERT_IMP(a_month_range, (state_q == S_MONTH),
		((mcnt_q >= MONTH_FIRST) && (mcnt_q <= MONTH_LAST)), "month counter out of range")
	`GDAD_ASSERT_IMP(a_year_range, (state_q == S_YEAR),
		((year_q != 14'd0) && (year_q <= YEAR_MAX)), "year left 1..9999 while stepping")
	`GDAD_ASSERT_NXT(a_year_step,
		((state_q == S_YEAR) && alu_gt && (year_q < YEAR_MAX)),
		(year_q == $past(year_q) + 14'd1), "year step lost")
	`GDAD_ASSERT_IMP(a_day_range, ((state_q == S_DONE) && !over_q),
		((acc_q != '0) && (acc_q <= UNIT_W'(DAY_LAST))), "day of month out of range")

endmodule

// ===== rtl/gregorian_date_add_days.sv =====
// Gregorian date adder: date plus a day count gives a later date.
// Input channel: date_valid/date_stall with start_year, start_month,
// start_day and days_to_add; an item is taken when valid is high and
// stall is low. date_stall stays high from acceptance until the result
// has moved into the output register.
// Output channel: result_valid/result_stall with result_year,
// result_month, result_day and year_overflow. The output register holds
// a result while result_stall is high, and a new date may be accepted
// in the meantime; the finished next result then waits in the
// sequencer until the register frees.
// Steps in order: year reduced modulo 400, day clamped, lengths of the
// months before the start month summed, the count added, whole years
// stepped off, then months stepped off. One item is in work at a time;
// all steps share one add/subtract unit.
// Reset (arst_n low) empties the sequencer and the output register.
// Uses gdad_pkg, gdad_alu, gdad_seq and the assertion macros.
`include "gregorian_date_add_days_macros.svh"

module gregorian_date_add_days
	import gdad_pkg::*;
#(
	parameter int COUNT_WIDTH = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   date_valid,
	output logic                   date_stall,
	input  logic [13:0]            start_year,
	input  logic [3:0]             start_month,
	input  logic [4:0]             start_day,
	input  logic [COUNT_WIDTH-1:0] days_to_add,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [13:0]            result_year,
	output logic [3:0]             result_month,
	output logic [4:0]             result_day,
	output logic                   year_overflow
);

	localparam int REM_W  = COUNT_WIDTH + 2;
	localparam int UNIT_W = (REM_W > 14) ? REM_W : 14;

	logic              busy;
	logic              start;
	logic              take;
	done_t             done;
	logic [UNIT_W-1:0] alu_a;
	logic [UNIT_W-1:0] alu_b;
	logic              alu_sub;
	logic [UNIT_W-1:0] alu_value;
	logic              alu_neg;
	logic              alu_zero;
	logic              valid_q;

	assign date_stall = busy;
	assign start      = date_valid && !busy;
	assign take       = done.valid && (!valid_q || !result_stall);

	gdad_alu #(
		.W(UNIT_W)
	) u_alu (
		.op_a  (alu_a),
		.op_b  (alu_b),
		.sub   (alu_sub),
		.value (alu_value),
		.neg   (alu_neg),
		.zero  (alu_zero)
	);

	gdad_seq #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.UNIT_W     (UNIT_W)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.start_year  (start_year),
		.start_month (start_month),
		.start_day   (start_day),
		.count       (days_to_add),
		.busy        (busy),
		.alu_a       (alu_a),
		.alu_b       (alu_b),
		.alu_sub     (alu_sub),
		.alu_value   (alu_value),
		.alu_neg     (alu_neg),
		.alu_zero    (alu_zero),
		.done        (done),
		.take        (take)
	);

	// Output valid: set on load, drop once the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Output payload: load the finished date, hold while stalled
	always_ff @(posedge clk) begin
		if (take) begin
			result_year   <= done.year;
			result_month  <= done.month;
			result_day    <= done.day;
			year_overflow <= done.over;
		end
	end

	assign result_valid = valid_q;

	`GDAD_ASSERT_IMP(a_out_year, valid_q,
		((result_year != 14'd0) && (result_year <= YEAR_MAX)), "result year out of range")
	`GDAD_ASSERT_IMP(a_out_sat, (valid_q && year_overflow),
		((result_year == YEAR_MAX) && (result_month == MONTH_LAST) &&
		(result_day == DAY_LAST)), "overflow result not saturated")

endmodule
